@@ rtl/lsst_pkg.sv @@
// ----------------------------------------------------------------------------
// Link session security tracker package
// Action, status, admission and level codes and the request/result structs.
// ----------------------------------------------------------------------------
`default_nettype none

package lsst_pkg;

    // Action codes carried in a request.
    localparam logic [4:0] ACT_CONNECT       = 5'd0;
    localparam logic [4:0] ACT_DISCONNECT    = 5'd1;
    localparam logic [4:0] ACT_ENCRYPTED     = 5'd2;
    localparam logic [4:0] ACT_BOND          = 5'd3;
    localparam logic [4:0] ACT_CLEAR_SEC     = 5'd4;
    localparam logic [4:0] ACT_BEGIN         = 5'd5;
    localparam logic [4:0] ACT_AUTHENTICATE  = 5'd6;
    localparam logic [4:0] ACT_OPEN          = 5'd7;
    localparam logic [4:0] ACT_CLOSE         = 5'd8;
    localparam logic [4:0] ACT_SET_AUTH      = 5'd9;
    localparam logic [4:0] ACT_MATCH         = 5'd10;
    localparam logic [4:0] ACT_MATCH_CUR     = 5'd11;
    localparam logic [4:0] ACT_IDENTITY      = 5'd12;
    localparam logic [4:0] ACT_CONN_WINDOW   = 5'd13;
    localparam logic [4:0] ACT_PAIR_WINDOW   = 5'd14;
    localparam logic [4:0] ACT_TRANSITIONING = 5'd15;
    localparam logic [4:0] ACT_ERROR         = 5'd16;
    localparam logic [4:0] ACT_SOFT_RESET    = 5'd17;
    localparam logic [4:0] ACT_QUERY         = 5'd18;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_STATE = 2'd1;
    localparam logic [1:0] ST_ARG   = 2'd2;

    // Channel codes for admission queries.
    localparam logic [1:0] CH_LINK    = 2'd0;
    localparam logic [1:0] CH_SESSION = 2'd1;

    // Admission codes.
    localparam logic [1:0] ADM_OK           = 2'd0;
    localparam logic [1:0] ADM_UNAVAILABLE  = 2'd1;
    localparam logic [1:0] ADM_UNAUTH       = 2'd2;
    localparam logic [1:0] ADM_DENIED       = 2'd3;

    // Session level codes.
    localparam logic [1:0] LVL_INACTIVE   = 2'd0;
    localparam logic [1:0] LVL_CONNECTED  = 2'd1;
    localparam logic [1:0] LVL_AUTHENTIC  = 2'd2;
    localparam logic [1:0] LVL_AUTHORIZED = 2'd3;

    // Saturation value of the epoch and revision counters.
    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [4:0]  action;
        logic [31:0] generation;
        logic        flag_value;
        logic [31:0] epoch_in;
        logic [31:0] revision_in;
        logic [1:0]  channel;
    } lsst_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] epoch_out;
        logic [1:0]  admission;
        logic [1:0]  session_level;
        logic [7:0]  state_flags;
        logic        bond_ok;
        logic        identity_ok;
        logic        link_window_open;
        logic        revision_exhausted;
    } lsst_out_t;

endpackage

`default_nettype wire

@@ rtl/link_session_security_tracker.sv @@
// ----------------------------------------------------------------------------
// Link session security tracker
// Applies one security life-cycle action per request and reports the result.
// ----------------------------------------------------------------------------
// Usage:
//   A request enters on in_valid/in_stall with an lsst_in_t payload and is
//   taken at an edge where in_valid is high and in_stall is low. Each request
//   gives exactly one result on out_valid/out_stall as an lsst_out_t.
//   The request is registered, then one pass of short logic updates the
//   tracker state and loads the result register, from which the result is
//   taken. Throughput is one request per cycle while the receiver does not
//   stall; the single state update per cycle sets that figure.
//   When the receiver stalls, the result register holds and the request
//   register fills; in_stall then rises until the result is taken.
//   The boot identifier is written on cfg_valid/cfg_ready (always ready)
//   and is only held; it is kept across a soft-reset action.
//   rst_n clears all tracker state, the epoch and both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module link_session_security_tracker
    import lsst_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire lsst_in_t   in_data,
    output logic            out_valid,
    input  wire logic       out_stall,
    output lsst_out_t       out_data,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [63:0] cfg_data
);

    // Pipeline registers.
    logic      in_valid_reg, in_valid_next;
    lsst_in_t  in_item_reg;
    logic      out_valid_reg, out_valid_next;
    lsst_out_t out_item_reg, out_item_next;
    logic      advance;

    // Configuration register.
    logic [63:0] boot_id_reg;

    // Tracker state.
    logic [31:0] current_gen_reg, current_gen_next;
    logic [31:0] highest_gen_reg, highest_gen_next;
    logic [31:0] epoch_reg, epoch_next;
    logic [31:0] revision_reg, revision_next;
    logic        active_reg, active_next;
    logic        encrypted_reg, encrypted_next;
    logic        bond_reg, bond_next;
    logic        identity_reg, identity_next;
    logic        conn_window_reg, conn_window_next;
    logic        handshaking_reg, handshaking_next;
    logic        open_reg, open_next;
    logic        authorized_reg, authorized_next;
    logic        bound_reg, bound_next;
    logic        transition_reg, transition_next;
    logic        error_reg, error_next;
    logic        pair_window_reg, pair_window_next;

    // Handshake control.
    assign advance        = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall       = in_valid_reg && !advance;
    assign out_valid      = out_valid_reg;
    assign out_data       = out_item_reg;
    assign cfg_ready      = 1'b1;
    assign in_valid_next  = in_stall ? in_valid_reg : in_valid;
    assign out_valid_next = advance ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            in_item_reg <= in_data;
        end
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    // Boot identifier register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boot_id_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            boot_id_reg <= cfg_data;
        end
    end

    // One pass: apply the action, then derive the result from the new state.
    always_comb
    begin
        logic [1:0]  st;
        logic [31:0] g;
        logic [31:0] rev;
        logic        fv;
        logic        live_in;
        logic        live;
        logic        secure;
        logic        match_ok;
        logic [7:0]  flags;
        logic [1:0]  adm;
        logic [1:0]  lvl;

        current_gen_next = current_gen_reg;
        highest_gen_next = highest_gen_reg;
        epoch_next       = epoch_reg;
        revision_next    = revision_reg;
        active_next      = active_reg;
        encrypted_next   = encrypted_reg;
        bond_next        = bond_reg;
        identity_next    = identity_reg;
        conn_window_next = conn_window_reg;
        handshaking_next = handshaking_reg;
        open_next        = open_reg;
        authorized_next  = authorized_reg;
        bound_next       = bound_reg;
        transition_next  = transition_reg;
        error_next       = error_reg;
        pair_window_next = pair_window_reg;

        st      = ST_OK;
        g       = in_item_reg.generation;
        fv      = in_item_reg.flag_value;
        rev     = in_item_reg.revision_in;
        live_in = (g == current_gen_reg) && active_reg;
        match_ok = live_in && open_reg && bound_reg
                   && ((rev == '0) || (rev == revision_reg));

        case (in_item_reg.action)
            ACT_CONNECT:
            begin
                if (g > highest_gen_reg)
                begin
                    if (active_reg)
                    begin
                        st = ST_STATE;
                    end
                    else
                    begin
                        highest_gen_next = g;
                        current_gen_next = g;
                        active_next      = 1'b1;
                        encrypted_next   = 1'b0;
                        bond_next        = 1'b0;
                        identity_next    = 1'b0;
                        open_next        = 1'b0;
                        authorized_next  = 1'b0;
                    end
                end
            end
            ACT_DISCONNECT:
            begin
                if (g == current_gen_reg)
                begin
                    active_next      = 1'b0;
                    encrypted_next   = 1'b0;
                    bond_next        = 1'b0;
                    identity_next    = 1'b0;
                    handshaking_next = 1'b0;
                    open_next        = 1'b0;
                    authorized_next  = 1'b0;
                end
            end
            ACT_ENCRYPTED:
            begin
                if (live_in)
                begin
                    encrypted_next = 1'b1;
                end
            end
            ACT_BOND:
            begin
                if (live_in)
                begin
                    bond_next = 1'b1;
                end
            end
            ACT_CLEAR_SEC:
            begin
                if (live_in)
                begin
                    encrypted_next = 1'b0;
                    bond_next      = 1'b0;
                    identity_next  = 1'b0;
                end
            end
            ACT_BEGIN, ACT_OPEN:
            begin
                if (!live_in)
                begin
                    st = ST_STATE;
                end
                else
                begin
                    handshaking_next = 1'b0;
                    open_next        = 1'b0;
                    authorized_next  = 1'b0;
                    if (epoch_reg == CNT_MAX)
                    begin
                        st = ST_STATE;
                    end
                    else
                    begin
                        // Open also completes authentication on the new epoch.
                        epoch_next = epoch_reg + 32'd1;
                        if (in_item_reg.action == ACT_OPEN)
                        begin
                            open_next = 1'b1;
                        end
                        else
                        begin
                            handshaking_next = 1'b1;
                        end
                    end
                end
            end
            ACT_AUTHENTICATE:
            begin
                if (live_in && handshaking_reg && (in_item_reg.epoch_in == epoch_reg))
                begin
                    handshaking_next = 1'b0;
                    open_next        = 1'b1;
                end
                else
                begin
                    st = ST_STATE;
                end
            end
            ACT_CLOSE:
            begin
                if (!live_in)
                begin
                    st = ST_STATE;
                end
                else
                begin
                    if (epoch_reg != CNT_MAX)
                    begin
                        epoch_next = epoch_reg + 32'd1;
                    end
                    handshaking_next = 1'b0;
                    open_next        = 1'b0;
                    authorized_next  = 1'b0;
                end
            end
            ACT_SET_AUTH:
            begin
                if ((rev == '0) && (revision_reg == CNT_MAX))
                begin
                    // Revision space used up: only a revoke is allowed.
                    if (fv)
                    begin
                        st = ST_STATE;
                    end
                    else
                    begin
                        bound_next      = 1'b0;
                        authorized_next = 1'b0;
                    end
                end
                else if ((rev == '0) || (rev > revision_reg))
                begin
                    revision_next   = (rev == '0) ? revision_reg + 32'd1 : rev;
                    bound_next      = fv;
                    authorized_next = 1'b0;
                end
            end
            ACT_MATCH:
            begin
                if (match_ok && (in_item_reg.epoch_in == epoch_reg))
                begin
                    authorized_next = 1'b1;
                end
                else
                begin
                    st = ST_STATE;
                end
            end
            ACT_MATCH_CUR:
            begin
                if (match_ok)
                begin
                    authorized_next = 1'b1;
                end
                else
                begin
                    st = ST_STATE;
                end
            end
            ACT_IDENTITY:
            begin
                if (!live_in)
                begin
                    st = ST_STATE;
                end
                else
                begin
                    identity_next = fv;
                    if (!fv)
                    begin
                        authorized_next = 1'b0;
                    end
                end
            end
            ACT_CONN_WINDOW:
            begin
                if (!live_in)
                begin
                    st = ST_STATE;
                end
                else
                begin
                    conn_window_next = fv;
                end
            end
            ACT_PAIR_WINDOW:
            begin
                pair_window_next = fv;
            end
            ACT_TRANSITIONING:
            begin
                transition_next = fv;
            end
            ACT_ERROR:
            begin
                if (fv)
                begin
                    error_next = 1'b1;
                end
            end
            ACT_SOFT_RESET:
            begin
                // Every tracker state register but the session epoch returns to its reset value.
                current_gen_next = '0;
                highest_gen_next = '0;
                revision_next    = '0;
                active_next      = 1'b0;
                encrypted_next   = 1'b0;
                bond_next        = 1'b0;
                identity_next    = 1'b0;
                conn_window_next = 1'b0;
                handshaking_next = 1'b0;
                open_next        = 1'b0;
                authorized_next  = 1'b0;
                bound_next       = 1'b0;
                transition_next  = 1'b0;
                error_next       = 1'b0;
                pair_window_next = 1'b0;
            end
            ACT_QUERY:
            begin
                st = ST_OK;
            end
            default:
            begin
                st = ST_ARG;
            end
        endcase

        // Result fields from the updated state.
        live   = (g == current_gen_next) && active_next;
        secure = encrypted_next && bond_next && identity_next;

        if (!live)
        begin
            adm = ADM_UNAVAILABLE;
        end
        else if (in_item_reg.channel == CH_LINK)
        begin
            adm = ADM_OK;
        end
        else if (in_item_reg.channel == CH_SESSION)
        begin
            adm = secure ? ADM_OK : ADM_UNAUTH;
        end
        else if (!secure || !open_next)
        begin
            adm = ADM_UNAUTH;
        end
        else
        begin
            adm = authorized_next ? ADM_OK : ADM_DENIED;
        end

        if (!live)
        begin
            lvl = LVL_INACTIVE;
        end
        else if (secure && open_next && authorized_next)
        begin
            lvl = LVL_AUTHORIZED;
        end
        else if (secure)
        begin
            lvl = LVL_AUTHENTIC;
        end
        else
        begin
            lvl = LVL_CONNECTED;
        end

        flags    = '0;
        flags[0] = active_next;
        flags[1] = pair_window_next && !bound_next;
        flags[2] = !(pair_window_next && !bound_next) && active_next && !pair_window_next;
        flags[3] = bound_next;
        flags[4] = bound_next && secure && open_next;
        flags[5] = authorized_next;
        flags[6] = handshaking_next || transition_next;
        flags[7] = error_next || (epoch_next == CNT_MAX);

        out_item_next.status             = st;
        out_item_next.epoch_out          = epoch_next;
        out_item_next.admission          = adm;
        out_item_next.session_level      = lvl;
        out_item_next.state_flags        = flags;
        out_item_next.bond_ok            = live && bond_next;
        out_item_next.identity_ok        = live && identity_next;
        out_item_next.link_window_open   = live && conn_window_next;
        out_item_next.revision_exhausted = (revision_next == CNT_MAX);
    end

    // Tracker state registers, updated once per processed request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_gen_reg <= '0;
            highest_gen_reg <= '0;
            epoch_reg       <= '0;
            revision_reg    <= '0;
            active_reg      <= 1'b0;
            encrypted_reg   <= 1'b0;
            bond_reg        <= 1'b0;
            identity_reg    <= 1'b0;
            conn_window_reg <= 1'b0;
            handshaking_reg <= 1'b0;
            open_reg        <= 1'b0;
            authorized_reg  <= 1'b0;
            bound_reg       <= 1'b0;
            transition_reg  <= 1'b0;
            error_reg       <= 1'b0;
            pair_window_reg <= 1'b0;
        end
        else if (advance)
        begin
            current_gen_reg <= current_gen_next;
            highest_gen_reg <= highest_gen_next;
            epoch_reg       <= epoch_next;
            revision_reg    <= revision_next;
            active_reg      <= active_next;
            encrypted_reg   <= encrypted_next;
            bond_reg        <= bond_next;
            identity_reg    <= identity_next;
            conn_window_reg <= conn_window_next;
            handshaking_reg <= handshaking_next;
            open_reg        <= open_next;
            authorized_reg  <= authorized_next;
            bound_reg       <= bound_next;
            transition_reg  <= transition_next;
            error_reg       <= error_next;
            pair_window_reg <= pair_window_next;
        end
    end

    // The boot identifier is only held; no output of the module reads it.
    logic boot_id_unused;
    assign boot_id_unused = ^boot_id_reg;

    // The current generation never passes the high-water mark.
    assert property (@(posedge clk) disable iff (!rst_n)
        current_gen_reg <= highest_gen_reg)
        else $error("current generation above high-water mark");

    // An authorized session is always an open one.
    assert property (@(posedge clk) disable iff (!rst_n)
        authorized_reg |-> open_reg)
        else $error("authorized without an open session");

    // A handshake in progress and an open session exclude each other.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(handshaking_reg && open_reg))
        else $error("handshaking and open at once");

    // The session epoch never goes backward.
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> epoch_reg >= $past(epoch_reg))
        else $error("session epoch decreased");

    // Requests are held back only while a finished result is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall && in_valid_reg))
        else $error("request stalled without a stalled result");

endmodule

`default_nettype wire
